@@ design/gd3_pkg.sv @@
// Shared types, constants and helpers for the 3x3 grayscale dilation unit.
// No dependencies; used by every module of the block.
package gd3_pkg;

  // Pixel and register field widths
  localparam int PIX_W       = 8;
  localparam int WIDTH_REG_W = 11;
  localparam int ROW_W       = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;

  // Defaults and limits
  localparam int MAX_COLS_DEF = 1024;
  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 11'd128;
  localparam logic [ROW_W-1:0]       HEIGHT_RESET = 13'd128;
  localparam logic [ROW_W-1:0]       HEIGHT_LIMIT = 13'd4096;

  // Item kinds
  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_FLUSH = 1'b1
  } mode_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    mode_e            mode;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;
  } out_item_t;

  // Per-word control decided at accept time, consumed by the window stage
  typedef struct packed {
    logic emit_start;  // row start: emit last pixel of the row two above
    logic emit_inner;  // inside a row: emit pixel one left, one up
    logic frame_end;   // last output of the frame, restart afterwards
    logic use_top;     // older store holds a real row
    logic use_mid;     // newer store holds a real row
    logic use_bot;     // incoming pixel is real (not draining)
    logic wide;        // image at least two pixels wide
    logic col_ge2;     // leftmost window column lies inside the image
  } ctrl_t;

  function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    max2 = (a > b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] max3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    max3 = max2(max2(a, b), c);
  endfunction

endpackage

@@ design/gd3_line_store.sv @@
// Two row stores (older and newer row) in block memory with registered read.
// Depends on gd3_pkg; forwards a same-address write into the read result.
module gd3_line_store #(
  parameter int MAX_COLS = gd3_pkg::MAX_COLS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [$clog2(MAX_COLS)-1:0] rd_addr_i,
  input  logic                       wr_en_i,
  input  logic [$clog2(MAX_COLS)-1:0] wr_addr_i,
  input  logic [gd3_pkg::PIX_W-1:0]  newer_wdata_i,
  output logic [gd3_pkg::PIX_W-1:0]  top_o,
  output logic [gd3_pkg::PIX_W-1:0]  mid_o
);

  logic [gd3_pkg::PIX_W-1:0] older_mem [MAX_COLS];
  logic [gd3_pkg::PIX_W-1:0] newer_mem [MAX_COLS];

  logic [gd3_pkg::PIX_W-1:0] older_rd_q, newer_rd_q;
  logic [gd3_pkg::PIX_W-1:0] fwd_top_q, fwd_mid_q;
  logic                      fwd_q;
  logic                      hit;

  assign hit = wr_en_i && (wr_addr_i == rd_addr_i);

  // Shift the column down: older takes what newer held, newer takes the pixel
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      older_mem[wr_addr_i] <= mid_o;
      newer_mem[wr_addr_i] <= newer_wdata_i;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      older_rd_q <= older_mem[rd_addr_i];
      newer_rd_q <= newer_mem[rd_addr_i];
      fwd_top_q  <= mid_o;
      fwd_mid_q  <= newer_wdata_i;
    end
  end

  // Remember whether the read collided with a write in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= hit;
    end
  end

  assign top_o = fwd_q ? fwd_top_q : older_rd_q;
  assign mid_o = fwd_q ? fwd_mid_q : newer_rd_q;

endmodule

@@ design/gd3_window.sv @@
// 3x3 window of pixels and the neighborhood maximum for one word.
// Depends on gd3_pkg for the control struct and max helpers.
module gd3_window (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  logic                      adv_i,
  input  gd3_pkg::ctrl_t            ctrl_i,
  input  logic [gd3_pkg::PIX_W-1:0] pix_i,
  input  logic [gd3_pkg::PIX_W-1:0] top_i,
  input  logic [gd3_pkg::PIX_W-1:0] mid_i,
  output logic [gd3_pkg::PIX_W-1:0] result_o
);

  // [column][row], column 2 newest, row 0 top
  logic [2:0][2:0][gd3_pkg::PIX_W-1:0] win_q, win_d;
  logic [gd3_pkg::PIX_W-1:0] top, mid, bot;
  logic [gd3_pkg::PIX_W-1:0] max_new, max_c2, max_c1;
  logic [gd3_pkg::PIX_W-1:0] start_val, inner_val;

  // Mask rows that lie outside the image
  assign top = ctrl_i.use_top ? top_i : '0;
  assign mid = ctrl_i.use_mid ? mid_i : '0;
  assign bot = ctrl_i.use_bot ? pix_i : '0;

  assign max_new = gd3_pkg::max3(top, mid, bot);
  assign max_c2  = gd3_pkg::max3(win_q[2][0], win_q[2][1], win_q[2][2]);
  assign max_c1  = gd3_pkg::max3(win_q[1][0], win_q[1][1], win_q[1][2]);

  // Row start uses the window before the shift, inner outputs after it
  assign start_val = gd3_pkg::max2(max_c2, ctrl_i.wide ? max_c1 : '0);
  assign inner_val = gd3_pkg::max3(max_new, max_c2, ctrl_i.col_ge2 ? max_c1 : '0);
  assign result_o  = ctrl_i.emit_start ? start_val : inner_val;

  // Shift in the new column, or clear at the end of the frame or on a restart
  always_comb begin
    win_d = win_q;
    if (clear_i) begin
      win_d = '0;
    end else if (adv_i) begin
      if (ctrl_i.frame_end) begin
        win_d = '0;
      end else begin
        win_d[0] = win_q[1];
        win_d[1] = win_q[2];
        win_d[2] = {bot, mid, top};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

endmodule

@@ design/grayscale_dilate_3x3_unit.sv @@
// Streaming 3x3 grayscale dilation (max filter) over a raster image, one pixel
// per word. Depends on gd3_pkg, gd3_line_store and gd3_window.
//
// The unit takes one word per clock cycle unless a result waiting in the output
// register holds the window stage. Each word is held in the window stage
// register and its result, if any, is loaded into the output register, which
// lets the next word enter while a result waits. The pace is set by the row
// stores: each word reads its column from both block memories as it is accepted,
// with registered read ahead of the window stage, and writes it back there, with
// same-address forwarding. Output trails input by one row plus one pixel, so
// after the last pixel of a frame send image_width + 1 flush words; the last
// result carries frame_last and the unit restarts. Flush words sent before the
// frame is complete are dropped. Writing the width or height register restarts
// the frame; write only while the unit is idle. Store contents are not cleared
// after reset and need no clearing pass.
module grayscale_dilate_3x3_unit #(
  parameter int MAX_COLS = gd3_pkg::MAX_COLS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  gd3_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output gd3_pkg::out_item_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gd3_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gd3_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int AW = $clog2(MAX_COLS);
  localparam int WW = $clog2(MAX_COLS + 1);

  // Configuration
  logic [gd3_pkg::WIDTH_REG_W-1:0] width_q;
  logic [gd3_pkg::ROW_W-1:0]       height_q;
  logic [WW-1:0]                   eff_w;
  logic [gd3_pkg::ROW_W-1:0]       eff_h;
  logic                            cfg_fire;
  logic                            cfg_restart;

  // Input position
  logic [AW-1:0]             col_q;
  logic [gd3_pkg::ROW_W-1:0] row_q;

  // Window stage and output register
  logic                      s1_valid_q;
  gd3_pkg::ctrl_t            s1_ctrl_q, ctrl_d;
  logic [gd3_pkg::PIX_W-1:0] s1_pix_q;
  logic [AW-1:0]             s1_addr_q;
  logic                      out_valid_q;
  gd3_pkg::out_item_t        out_data_q;

  logic in_fire, take, draining, col_last, s1_emit, s1_adv, out_free;
  logic [gd3_pkg::PIX_W-1:0] top_rd, mid_rd, result;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // Only a write to a known register restarts the frame
  assign cfg_restart = cfg_fire &&
                       (cfg_index_i inside {gd3_pkg::CFG_IMAGE_WIDTH,
                                            gd3_pkg::CFG_IMAGE_HEIGHT});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gd3_pkg::WIDTH_RESET;
      height_q <= gd3_pkg::HEIGHT_RESET;
    end else if (cfg_fire) begin
      case (cfg_index_i)
        gd3_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i[gd3_pkg::WIDTH_REG_W-1:0];
        gd3_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp width and height to their usable ranges
  always_comb begin
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (32'(width_q) > MAX_COLS) begin
      eff_w = WW'(MAX_COLS);
    end else begin
      eff_w = WW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = gd3_pkg::ROW_W'(1);
    end else if (height_q > gd3_pkg::HEIGHT_LIMIT) begin
      eff_h = gd3_pkg::HEIGHT_LIMIT;
    end else begin
      eff_h = height_q;
    end
  end

  // Handshake: advance the window stage when its result has a place to go or it has none
  assign s1_emit  = s1_ctrl_q.emit_start || s1_ctrl_q.emit_inner;
  assign out_free = !out_valid_q || out_ready_i;
  assign s1_adv   = s1_valid_q && (out_free || !s1_emit);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire  = in_valid_i && in_ready_o;

  // Classify the word at the current position
  assign draining = row_q >= eff_h;
  assign col_last = ({1'b0, col_q} + (AW+1)'(1)) >= (AW+1)'(eff_w);
  assign take     = in_fire && !(in_data_i.mode == gd3_pkg::MODE_FLUSH && !draining);

  always_comb begin
    ctrl_d.emit_start = (col_q == '0) && (row_q >= gd3_pkg::ROW_W'(2));
    ctrl_d.frame_end  = ctrl_d.emit_start && (row_q >= (eff_h + gd3_pkg::ROW_W'(1)));
    ctrl_d.emit_inner = (col_q != '0) && (row_q != '0);
    ctrl_d.use_top    = row_q >= gd3_pkg::ROW_W'(2);
    ctrl_d.use_mid    = row_q != '0;
    ctrl_d.use_bot    = !draining;
    ctrl_d.wide       = eff_w >= WW'(2);
    ctrl_d.col_ge2    = col_q >= AW'(2);
  end

  // Advance the raster position, restart at frame end or on a register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_restart) begin
      col_q <= '0;
      row_q <= '0;
    end else if (take) begin
      if (ctrl_d.frame_end) begin
        col_q <= '0;
        row_q <= '0;
      end else if (col_last) begin
        col_q <= '0;
        row_q <= row_q + gd3_pkg::ROW_W'(1);
      end else begin
        col_q <= col_q + AW'(1);
      end
    end
  end

  // Window stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Window stage payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_ctrl_q <= ctrl_d;
      s1_pix_q  <= in_data_i.pixel_in;
      s1_addr_q <= col_q;
    end
  end

  gd3_line_store #(
    .MAX_COLS (MAX_COLS)
  ) u_line_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_en_i       (take),
    .rd_addr_i     (col_q),
    .wr_en_i       (s1_adv && s1_ctrl_q.use_bot),
    .wr_addr_i     (s1_addr_q),
    .newer_wdata_i (s1_pix_q),
    .top_o         (top_rd),
    .mid_o         (mid_rd)
  );

  gd3_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (cfg_restart),
    .adv_i    (s1_adv),
    .ctrl_i   (s1_ctrl_q),
    .pix_i    (s1_pix_q),
    .top_i    (top_rd),
    .mid_i    (mid_rd),
    .result_o (result)
  );

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit) begin
      out_data_q.pixel_out  <= result;
      out_data_q.frame_last <= s1_ctrl_q.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A word in the window stage stays until it advances
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q)
    else $error("window stage word lost");

  // Column position stays inside the row
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, col_q} < (AW+1)'(eff_w)))
    else $error("column position beyond image width");

  // Row position never passes the last drain row
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= (eff_h + gd3_pkg::ROW_W'(1)))
    else $error("row position beyond drain rows");

  // At most one result per word
  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> !(s1_ctrl_q.emit_start && s1_ctrl_q.emit_inner))
    else $error("word would emit two results");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for grayscale_dilate_3x3_unit: directed table, then random frames
// checked word by word against a behavioral max-filter predictor. Depends on gd3_pkg.
module testbench;

  localparam int unsigned CYCLE_LIMIT   = 400_000;
  localparam int unsigned QUIET_HOLD    = 8;
  localparam int          DIRECTED_ROWS = 25;
  localparam int          CFG_HI_W      = gd3_pkg::CFG_DATA_W - gd3_pkg::WIDTH_REG_W;

  // One row of the directed table: either a register write or a word
  typedef struct packed {
    logic                           is_cfg;
    gd3_pkg::cfg_reg_e              reg_sel;
    logic [gd3_pkg::CFG_DATA_W-1:0] value;
    gd3_pkg::mode_e                 mode;
    logic [gd3_pkg::PIX_W-1:0]      pixel;
    logic                           hand_checked;
    logic                           exp_has;
    logic [gd3_pkg::PIX_W-1:0]      exp_pixel;
    logic                           exp_last;
  } drow_t;

  logic                           clk_i;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  gd3_pkg::in_item_t              in_data_i   = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  gd3_pkg::out_item_t             out_data_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [gd3_pkg::CFG_IDX_W-1:0]  cfg_index_i = gd3_pkg::CFG_IMAGE_WIDTH;
  logic [gd3_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // Predictor state
  logic [gd3_pkg::PIX_W-1:0]       rows_older [gd3_pkg::MAX_COLS_DEF];
  logic [gd3_pkg::PIX_W-1:0]       rows_newer [gd3_pkg::MAX_COLS_DEF];
  logic [gd3_pkg::PIX_W-1:0]       window_px  [9];  // column * 3 + row, column 2 newest
  int unsigned                     col_pos;
  int unsigned                     row_pos;
  logic [gd3_pkg::WIDTH_REG_W-1:0] width_reg  = gd3_pkg::WIDTH_RESET;
  logic [gd3_pkg::ROW_W-1:0]       height_reg = gd3_pkg::HEIGHT_RESET;

  gd3_pkg::out_item_t dilated_due [$];
  int unsigned fail_count     = 0;
  int unsigned fed_words      = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;

  // Small frames whose results can be read off by hand
  drow_t directed_rows [DIRECTED_ROWS] = '{
    // default 128x128 frame: early flush is dropped
    '{1'b0, gd3_pkg::CFG_IMAGE_WIDTH,  13'd0, gd3_pkg::MODE_FLUSH, 8'hA5, 1'b1, 1'b0, 8'h00, 1'b0},
    // 2x2 frame: every output is the max of all four pixels
    '{1'b1, gd3_pkg::CFG_IMAGE_WIDTH,  13'd2, gd3_pkg::MODE_PIXEL, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{1'b1, gd3_pkg::CFG_IMAGE_HEIGHT, 13'd2, gd3_pkg::MODE_PIXEL, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{1'b0, gd3_pkg::CFG_IMAGE_WIDTH,  13'd0, gd3_pkg::MODE_PIXEL, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{1'b0, gd3_pkg::CFG_IMAGE_WIDTH,  13'd0, gd3_pkg::MODE_PIXEL, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
    '{1'b0, gd3_pkg::CFG_IMAGE_WIDTH,  13'd0, gd3_pkg::MODE_FLUSH, 8'h55, 1'b1, 1'b0, 8'h00, 1'b0},
    '{1'b0, gd3_pkg::CFG_IMAGE_WIDTH,  13'd0, gd3_pkg::MODE_PIXEL, 8'h01, 1'b1, 1'b0, 8'h00, 1'b0},
    '{1'b0, gd3_pkg::CFG_IMAGE_WIDTH,  13'd0, gd3_pkg::MODE_PIXEL, 8'h80, 1'b1, 1'b1, 8'hFF, 1'b0},
    // pixel word while draining counts as a flush
    '{1'b0, gd3_pkg::CFG_IMAGE_WIDTH,  13'd0, gd3_pkg::MODE_PIXEL, 8'h37, 1'b1, 1'b1, 8'hFF, 1'b0},
    '{1'b0, gd3_pkg::CFG_IMAGE_WIDTH,  13'd0, gd3_pkg::MODE_FLUSH, 8'h00, 1'b1, 1'b1, 8'hFF, 1'b0},
    '{1'b0, gd3_pkg::CFG_IMAGE_WIDTH,  13'd0, gd3_pkg::MODE_FLUSH, 8'h00, 1'b1, 1'b1, 8'hFF, 1'b1},
    // one-row frame: first flush yields nothing
    '{1'b1, gd3_pkg::CFG_IMAGE_WIDTH,  13'd3, gd3_pkg::MODE_PIXEL, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{1'b1, gd3_pkg::CFG_IMAGE_HEIGHT, 13'd1, gd3_pkg::MODE_PIXEL, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{1'b0, gd3_pkg::CFG_IMAGE_WIDTH,  13'd0, gd3_pkg::MODE_PIXEL, 8'h10, 1'b1, 1'b0, 8'h00, 1'b0},
    '{1'b0, gd3_pkg::CFG_IMAGE_WIDTH,  13'd0, gd3_pkg::MODE_PIXEL, 8'h20, 1'b1, 1'b0, 8'h00, 1'b0},
    '{1'b0, gd3_pkg::CFG_IMAGE_WIDTH,  13'd0, gd3_pkg::MODE_PIXEL, 8'h30, 1'b1, 1'b0, 8'h00, 1'b0},
    '{1'b0, gd3_pkg::CFG_IMAGE_WIDTH,  13'd0, gd3_pkg::MODE_FLUSH, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{1'b0, gd3_pkg::CFG_IMAGE_WIDTH,  13'd0, gd3_pkg::MODE_FLUSH, 8'h00, 1'b1, 1'b1, 8'h20, 1'b0},
    '{1'b0, gd3_pkg::CFG_IMAGE_WIDTH,  13'd0, gd3_pkg::MODE_FLUSH, 8'h00, 1'b1, 1'b1, 8'h30, 1'b0},
    '{1'b0, gd3_pkg::CFG_IMAGE_WIDTH,  13'd0, gd3_pkg::MODE_FLUSH, 8'h00, 1'b1, 1'b1, 8'h30, 1'b1},
    // zero width and height act as one
    '{1'b1, gd3_pkg::CFG_IMAGE_WIDTH,  13'd0, gd3_pkg::MODE_PIXEL, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{1'b1, gd3_pkg::CFG_IMAGE_HEIGHT, 13'd0, gd3_pkg::MODE_PIXEL, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{1'b0, gd3_pkg::CFG_IMAGE_WIDTH,  13'd0, gd3_pkg::MODE_PIXEL, 8'h5A, 1'b0, 1'b0, 8'h00, 1'b0},
    '{1'b0, gd3_pkg::CFG_IMAGE_WIDTH,  13'd0, gd3_pkg::MODE_FLUSH, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{1'b0, gd3_pkg::CFG_IMAGE_WIDTH,  13'd0, gd3_pkg::MODE_FLUSH, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0}
  };

  grayscale_dilate_3x3_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > gd3_pkg::MAX_COLS_DEF) return gd3_pkg::MAX_COLS_DEF;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    if (height_reg == 0) return 1;
    if (height_reg > gd3_pkg::HEIGHT_LIMIT) return gd3_pkg::HEIGHT_LIMIT;
    return height_reg;
  endfunction

  function automatic logic [gd3_pkg::PIX_W-1:0] column_peak(input int col);
    logic [gd3_pkg::PIX_W-1:0] peak;
    peak = window_px[col * 3];
    if (window_px[col * 3 + 1] > peak) peak = window_px[col * 3 + 1];
    if (window_px[col * 3 + 2] > peak) peak = window_px[col * 3 + 2];
    return peak;
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    foreach (window_px[k]) window_px[k] = '0;
  endfunction

  // Advance the model by one accepted word; report whether it was taken and its result
  function automatic void predict_dilation(input gd3_pkg::in_item_t word, output logic taken,
                                           output logic has_res,
                                           output gd3_pkg::out_item_t res);
    int unsigned               w, h, c, r;
    int                        k;
    logic                      draining;
    logic [gd3_pkg::PIX_W-1:0] top, mid, bot, peak;
    w        = active_width();
    h        = active_height();
    c        = col_pos;
    r        = row_pos;
    draining = (r >= h);
    taken    = 1'b1;
    has_res  = 1'b0;
    res      = '0;
    // drop flush words until the frame is fully in
    if (!draining && word.mode == gd3_pkg::MODE_FLUSH) begin
      taken = 1'b0;
      return;
    end
    // row start: finish the last pixel of the row two above
    if (c == 0 && r >= 2) begin
      peak = column_peak(2);
      if (w >= 2 && column_peak(1) > peak) peak = column_peak(1);
      has_res          = 1'b1;
      res.pixel_out    = peak;
      res.frame_last   = (r >= h + 1);
      if (res.frame_last) begin
        restart_frame();
        return;
      end
    end
    // shift in the new column vector and update the row stores
    top = (r >= 2) ? rows_older[c] : '0;
    mid = (r >= 1) ? rows_newer[c] : '0;
    bot = draining ? '0 : word.pixel_in;
    if (!draining) begin
      rows_older[c] = rows_newer[c];
      rows_newer[c] = word.pixel_in;
    end
    for (k = 0; k < 6; k++) window_px[k] = window_px[k + 3];
    window_px[6] = top;
    window_px[7] = mid;
    window_px[8] = bot;
    // inside a row: emit the pixel one left, one up
    if (c >= 1 && r >= 1) begin
      peak = column_peak(2);
      if (column_peak(1) > peak) peak = column_peak(1);
      if (c >= 2 && column_peak(0) > peak) peak = column_peak(0);
      has_res        = 1'b1;
      res.pixel_out  = peak;
      res.frame_last = 1'b0;
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  // ---------------------------------------------------------------- drivers

  function automatic logic [gd3_pkg::PIX_W-1:0] pick_pixel();
    int unsigned roll;
    roll = $urandom_range(7);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return gd3_pkg::PIX_W'($urandom_range(255));
  endfunction

  task automatic set_pace(input int unsigned send_pct, input int unsigned recv_pct);
    send_gap_pct   = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Hold the input side until every expected word is out, then let the pipe settle
  task automatic await_quiet();
    in_valid_i <= 1'b0;
    while (dilated_due.size() != 0) @(posedge clk_i);
    repeat (QUIET_HOLD) @(posedge clk_i);
  endtask

  // Offer one word, with random gaps first; return at the accepting edge
  task automatic send_word(input gd3_pkg::in_item_t word);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= word;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(input gd3_pkg::cfg_reg_e sel,
                           input logic [gd3_pkg::CFG_DATA_W-1:0] value);
    await_quiet();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_wdata_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (sel == gd3_pkg::CFG_IMAGE_WIDTH) width_reg = value[gd3_pkg::WIDTH_REG_W-1:0];
    else height_reg = value[gd3_pkg::ROW_W-1:0];
    restart_frame();
  endtask

  // Send one word, predict its result and queue it; pause for a full drain now and then
  task automatic feed_word(input gd3_pkg::mode_e mode,
                           input logic [gd3_pkg::PIX_W-1:0] pixel);
    gd3_pkg::in_item_t  word;
    logic               taken, has_res;
    gd3_pkg::out_item_t res;
    if ($urandom_range(49) == 0) await_quiet();
    word.mode     = mode;
    word.pixel_in = pixel;
    send_word(word);
    predict_dilation(word, taken, has_res, res);
    if (has_res) dilated_due.push_back(res);
    if (taken) fed_words++;
  endtask

  // Pick a small frame size, then send whole frames or a frame cut short
  task automatic run_random_phase();
    int unsigned                    pick, w_raw, h_raw, w, h, n, k;
    logic [gd3_pkg::CFG_DATA_W-1:0] w_value;
    pick = $urandom_range(99);
    if (pick < 8) w_raw = 0;
    else if (pick < 16) w_raw = 1;
    else if (pick < 24) w_raw = $urandom_range(24, 13);
    else w_raw = $urandom_range(9, 2);
    pick = $urandom_range(99);
    if (pick < 8) h_raw = 0;
    else if (pick < 18) h_raw = 1;
    else h_raw = $urandom_range(6, 2);
    // upper data bits lie beyond the width register and must be dropped
    w_value = gd3_pkg::CFG_DATA_W'(w_raw);
    if ($urandom_range(5) == 0)
      w_value[gd3_pkg::CFG_DATA_W-1:gd3_pkg::WIDTH_REG_W] = CFG_HI_W'($urandom_range(3, 1));
    if ($urandom_range(1) == 0) begin
      write_reg(gd3_pkg::CFG_IMAGE_WIDTH, w_value);
      write_reg(gd3_pkg::CFG_IMAGE_HEIGHT, gd3_pkg::CFG_DATA_W'(h_raw));
    end else begin
      write_reg(gd3_pkg::CFG_IMAGE_HEIGHT, gd3_pkg::CFG_DATA_W'(h_raw));
      write_reg(gd3_pkg::CFG_IMAGE_WIDTH, w_value);
    end
    w = active_width();
    h = active_height();
    if ($urandom_range(4) == 0) begin
      // cut the frame short; the next register write drops the rest
      n = $urandom_range(w * h + w, 1);
      for (k = 0; k < n; k++)
        feed_word(gd3_pkg::mode_e'(($urandom_range(6) == 0) ? gd3_pkg::MODE_FLUSH
                                                            : gd3_pkg::MODE_PIXEL),
                  pick_pixel());
    end else begin
      repeat ($urandom_range(2, 1)) begin
        for (k = 0; k < w * h; k++) begin
          if ($urandom_range(19) == 0) feed_word(gd3_pkg::MODE_FLUSH, pick_pixel());
          feed_word(gd3_pkg::MODE_PIXEL, pick_pixel());
        end
        for (k = 0; k <= w; k++)
          feed_word(gd3_pkg::mode_e'(($urandom_range(9) == 0) ? gd3_pkg::MODE_PIXEL
                                                              : gd3_pkg::MODE_FLUSH),
                    pick_pixel());
      end
    end
  endtask

  // ---------------------------------------------------------------- result check

  always @(posedge clk_i) begin : check_results
    gd3_pkg::out_item_t want;
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (dilated_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, got pixel %02h last %0b",
                 $time, out_data_o.pixel_out, out_data_o.frame_last);
        fail_count++;
      end else begin
        want = dilated_due.pop_front();
        if (out_data_o.pixel_out !== want.pixel_out) begin
          $display("%0t: pixel_out expected %02h, got %02h",
                   $time, want.pixel_out, out_data_o.pixel_out);
          fail_count++;
        end
        if (out_data_o.frame_last !== want.frame_last) begin
          $display("%0t: frame_last expected %0b, got %0b",
                   $time, want.frame_last, out_data_o.frame_last);
          fail_count++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    gd3_pkg::in_item_t  word;
    logic               taken, has_res;
    gd3_pkg::out_item_t res;
    int unsigned        k, goal;
    foreach (rows_older[idx]) begin
      rows_older[idx] = '0;
      rows_newer[idx] = '0;
    end
    restart_frame();
    set_pace(12, 48);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // walk the directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_reg(directed_rows[i].reg_sel, directed_rows[i].value);
      end else begin
        word.mode     = directed_rows[i].mode;
        word.pixel_in = directed_rows[i].pixel;
        send_word(word);
        predict_dilation(word, taken, has_res, res);
        if (directed_rows[i].hand_checked) begin
          has_res        = directed_rows[i].exp_has;
          res.pixel_out  = directed_rows[i].exp_pixel;
          res.frame_last = directed_rows[i].exp_last;
        end
        if (has_res) dilated_due.push_back(res);
      end
    end

    fed_words = 0;
    while (fed_words < 140) run_random_phase();

    set_pace(48, 12);
    // width above the limit clamps; frame cut short by the next write
    write_reg(gd3_pkg::CFG_IMAGE_WIDTH, 13'h07FF);
    write_reg(gd3_pkg::CFG_IMAGE_HEIGHT, 13'd2);
    for (k = 0; k < 30; k++) feed_word(gd3_pkg::MODE_PIXEL, pick_pixel());
    // tallest settings, cut short by the next write
    write_reg(gd3_pkg::CFG_IMAGE_WIDTH, 13'd1024);
    write_reg(gd3_pkg::CFG_IMAGE_HEIGHT, gd3_pkg::HEIGHT_LIMIT);
    for (k = 0; k < 40; k++) feed_word(gd3_pkg::MODE_PIXEL, pick_pixel());
    write_reg(gd3_pkg::CFG_IMAGE_WIDTH, 13'd3);
    write_reg(gd3_pkg::CFG_IMAGE_HEIGHT, 13'h1FFF);
    for (k = 0; k < 15; k++) feed_word(gd3_pkg::MODE_PIXEL, pick_pixel());
    goal = fed_words + 130;
    while (fed_words < goal) run_random_phase();

    set_pace(0, 0);
    goal = fed_words + 120;
    while (fed_words < goal) run_random_phase();

    await_quiet();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ grayscale_dilate_3x3_unit.f @@
design/gd3_pkg.sv
design/gd3_line_store.sv
design/gd3_window.sv
design/grayscale_dilate_3x3_unit.sv
tb/sv/testbench.sv
